// File: sv/iask_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the IMU acceleration Kalman smoother.
package iask_pkg;

    localparam int SAMPLE_WIDTH = 32;

    // Covariance format (unsigned Q2.30); noise and gain formats (unsigned Q1.30)
    localparam int FRAC_BITS  = 30;
    localparam int COV_W      = 32;
    localparam int REG_W      = 31;
    localparam int GAIN_W     = 31;
    localparam int DEN_W      = 33;

    localparam logic [COV_W-1:0]  COV_ONE   = COV_W'(1) << FRAC_BITS;
    localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << FRAC_BITS;
    localparam logic [REG_W-1:0]  Q_RESET   = REG_W'(107374);
    localparam logic [REG_W-1:0]  R_RESET   = REG_W'(10737418);

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROCESS_NOISE     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEASUREMENT_NOISE = 1'b1;

    typedef enum logic
    {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } mdu_op_t;

    typedef struct packed
    {
        logic    start;
        mdu_op_t op;
    } mdu_cmd_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } mdu_stat_t;

endpackage

// File: sv/imu_accel_scalar_kalman.sv
`timescale 1ns / 1ps
// Top level: IMU axis remap and scalar random-walk Kalman smoothing of three accelerations.
//
// Input stream s_*: one transfer carries one IMU sample (three accelerations, three
// angular rates, signed Q15.16). Output stream m_*: one transfer per sample with the
// three filtered accelerations (forward, lateral, vertical) and the remapped rates.
// Config port: cfg_we / cfg_index / cfg_data write Q (index 0) and R (index 1),
// unsigned Q1.30; write only while no sample is in flight.
// A new sample is taken the cycle after the result is loaded into the output
// register. The shared bit-serial unit sets the pace: a 31-step gain divide,
// a 31-step covariance multiply and three 31-step estimate multiplies, each
// followed by a finishing state.
// The result sits in an output register; s_tready returns while it waits for
// m_tready. If the receiver stalls longer than one sample time, the next result
// holds in the sequencer until the output register frees up.
// Reset clears the estimates, sets covariance to 1.0, marks the filter unseeded
// and loads the default Q and R. The first sample after reset seeds the estimates.
module imu_accel_scalar_kalman #(
    parameter int SAMPLE_WIDTH = iask_pkg::SAMPLE_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, zero pad
    input  logic [((6*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // filtered_forward, filtered_lateral, filtered_vertical,
    // roll_rate, pitch_rate, yaw_rate, zero pad
    output logic [((6*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
    input  logic                                cfg_we,
    input  logic [iask_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [iask_pkg::REG_W-1:0]          cfg_data
);

    localparam int W      = SAMPLE_WIDTH;
    localparam int TD_W   = ((6*SAMPLE_WIDTH+7)/8)*8;
    localparam int MW     = (W > iask_pkg::COV_W) ? W : iask_pkg::COV_W;
    localparam int COV_W  = iask_pkg::COV_W;
    localparam int GAIN_W = iask_pkg::GAIN_W;
    localparam int DEN_W  = iask_pkg::DEN_W;
    localparam logic [W-1:0] SMIN = W'(1) << (W - 1);
    localparam logic [W-1:0] SMAX = ~SMIN;
    localparam logic [1:0]   AXIS_LAST = 2'd2;

    typedef enum logic [6:0]
    {
        ST_IDLE  = 7'b0000001,
        ST_PREP  = 7'b0000010,
        ST_DIVW  = 7'b0000100,
        ST_PMULW = 7'b0001000,
        ST_DIFF  = 7'b0010000,
        ST_AMULW = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    function automatic logic [W-1:0] neg_sat(input logic [W-1:0] v);
        if (v == SMIN)
        begin
            return SMAX;
        end
        return W'(0) - v;
    endfunction

    state_t                  state_reg, state_next;
    logic [iask_pkg::REG_W-1:0] q_reg, r_reg;
    logic [W-1:0]            est_reg [3];
    logic [W-1:0]            est_next [3];
    logic [W-1:0]            meas_reg [3];
    logic [W-1:0]            meas_next [3];
    logic [W-1:0]            rate_reg [3];
    logic [W-1:0]            rate_next [3];
    logic [COV_W-1:0]        cov_reg, cov_next;
    logic                    seeded_reg, seeded_next;
    logic [COV_W-1:0]        pp_reg, pp_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [GAIN_W-1:0]       k_reg, k_next;
    logic [1:0]              axis_reg, axis_next;
    logic                    up_reg, up_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [TD_W-1:0]         m_tdata_reg, m_tdata_next;

    logic [W-1:0]            in_f [6];
    logic [W-1:0]            remap_acc [3];
    logic [W-1:0]            remap_rate [3];
    logic                    in_xfer;
    logic                    out_free;
    logic [COV_W:0]          pq_sum;
    logic [COV_W-1:0]        pp_comb;
    logic [DEN_W-1:0]        den_comb;
    logic [GAIN_W-1:0]       k_comb;
    logic [W:0]              diff;
    logic [W-1:0]            diff_neg;
    logic [W-1:0]            mag;
    logic [W-1:0]            step;
    logic [W-1:0]            est_sel;

    iask_pkg::mdu_cmd_t      mdu_cmd;
    iask_pkg::mdu_stat_t     mdu_stat;
    logic [MW-1:0]           mdu_opa;
    logic [GAIN_W-1:0]       mdu_opb;
    logic [MW-1:0]           mdu_result;

    iask_muldiv #(
        .OPW (MW)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (mdu_cmd),
        .opa    (mdu_opa),
        .opb    (mdu_opb),
        .den    (den_comb),
        .stat   (mdu_stat),
        .result (mdu_result)
    );

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            in_f[i] = s_tdata[i*W +: W];
        end
        remap_acc[0]  = in_f[2];
        remap_acc[1]  = neg_sat(in_f[0]);
        remap_acc[2]  = neg_sat(in_f[1]);
        remap_rate[0] = in_f[5];
        remap_rate[1] = neg_sat(in_f[3]);
        remap_rate[2] = neg_sat(in_f[4]);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Predicted covariance, saturating, and the gain denominator
    assign pq_sum   = {1'b0, cov_reg} + (COV_W+1)'(q_reg);
    assign pp_comb  = pq_sum[COV_W] ? '1 : pq_sum[COV_W-1:0];
    assign den_comb = (state_reg == ST_PREP) ? DEN_W'(pp_comb) + DEN_W'(r_reg) : den_reg;
    // Zero denominator means zero gain
    assign k_comb   = (den_reg == '0) ? '0 : mdu_result[GAIN_W-1:0];

    assign est_sel  = est_reg[axis_reg];
    assign diff     = {meas_reg[axis_reg][W-1], meas_reg[axis_reg]} - {est_sel[W-1], est_sel};
    assign diff_neg = W'(0) - diff[W-1:0];
    assign mag      = diff[W] ? diff_neg : diff[W-1:0];
    assign step     = mdu_result[W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        est_next      = est_reg;
        meas_next     = meas_reg;
        rate_next     = rate_reg;
        cov_next      = cov_reg;
        seeded_next   = seeded_reg;
        pp_next       = pp_reg;
        den_next      = den_reg;
        k_next        = k_reg;
        axis_next     = axis_reg;
        up_next       = up_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mdu_cmd.start = 1'b0;
        mdu_cmd.op    = iask_pkg::OP_MUL;
        mdu_opa       = MW'(pp_comb);
        mdu_opb       = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    meas_next = remap_acc;
                    rate_next = remap_rate;
                    if (!seeded_reg)
                    begin
                        est_next    = remap_acc;
                        cov_next    = iask_pkg::COV_ONE;
                        seeded_next = 1'b1;
                    end
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                pp_next       = pp_comb;
                den_next      = den_comb;
                mdu_cmd.start = 1'b1;
                mdu_cmd.op    = iask_pkg::OP_DIV;
                mdu_opa       = MW'(pp_comb);
                state_next    = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (mdu_stat.done)
                begin
                    k_next        = k_comb;
                    mdu_cmd.start = 1'b1;
                    mdu_opa       = MW'(pp_reg);
                    mdu_opb       = iask_pkg::GAIN_ONE - k_comb;
                    state_next    = ST_PMULW;
                end
            end
            ST_PMULW:
            begin
                if (mdu_stat.done)
                begin
                    cov_next   = mdu_result[COV_W-1:0];
                    axis_next  = '0;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                up_next       = !diff[W];
                mdu_cmd.start = 1'b1;
                mdu_opa       = MW'(mag);
                mdu_opb       = k_reg;
                state_next    = ST_AMULW;
            end
            ST_AMULW:
            begin
                if (mdu_stat.done)
                begin
                    est_next[axis_reg] = up_reg ? est_sel + step : est_sel - step;
                    if (axis_reg == AXIS_LAST)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tdata_next  = TD_W'({rate_reg[2], rate_reg[1], rate_reg[0],
                                           est_reg[2], est_reg[1], est_reg[0]});
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            q_reg        <= iask_pkg::Q_RESET;
            r_reg        <= iask_pkg::R_RESET;
            est_reg      <= '{default: '0};
            cov_reg      <= iask_pkg::COV_ONE;
            seeded_reg   <= 1'b0;
            axis_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            est_reg      <= est_next;
            cov_reg      <= cov_next;
            seeded_reg   <= seeded_next;
            axis_reg     <= axis_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    iask_pkg::CFG_PROCESS_NOISE:     q_reg <= cfg_data;
                    iask_pkg::CFG_MEASUREMENT_NOISE: r_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg    <= meas_next;
        rate_reg    <= rate_next;
        pp_reg      <= pp_next;
        den_reg     <= den_next;
        k_reg       <= k_next;
        up_reg      <= up_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_ready_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !mdu_stat.busy)
        else $error("input ready while shared unit busy");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PMULW) |-> (k_reg <= iask_pkg::GAIN_ONE))
        else $error("Kalman gain above 1.0");

    a_cov_not_grown: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIFF) |-> (cov_reg <= pp_reg))
        else $error("updated covariance exceeds prediction");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mdu_stat.done |-> (state_reg == ST_DIVW || state_reg == ST_PMULW ||
                           state_reg == ST_AMULW))
        else $error("shared unit finished with no waiting step");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIFF || state_reg == ST_AMULW) |-> (axis_reg <= AXIS_LAST))
        else $error("axis index out of range");
`endif

endmodule

// File: sv/iask_muldiv.sv
`timescale 1ns / 1ps
// Shared bit-serial unit: rounded Q30 multiply and restoring gain divide on one adder.
module iask_muldiv #(
    parameter int OPW = iask_pkg::SAMPLE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  iask_pkg::mdu_cmd_t             cmd,
    input  logic [OPW-1:0]                 opa,
    input  logic [iask_pkg::GAIN_W-1:0]    opb,
    input  logic [iask_pkg::DEN_W-1:0]     den,
    output iask_pkg::mdu_stat_t            stat,
    output logic [OPW-1:0]                 result
);

    localparam int AW     = (OPW > iask_pkg::DEN_W + 1) ? OPW : iask_pkg::DEN_W + 1;
    localparam int BW     = iask_pkg::GAIN_W;
    localparam int STEPS  = iask_pkg::GAIN_W;
    localparam int CNT_W  = $clog2(STEPS);

    typedef enum logic [2:0]
    {
        U_IDLE = 3'b001,
        U_RUN  = 3'b010,
        U_FIN  = 3'b100
    } ustate_t;

    ustate_t             state_reg, state_next;
    iask_pkg::mdu_op_t   op_reg, op_next;
    logic [AW-1:0]       acc_reg, acc_next;
    logic [BW-1:0]       bits_reg, bits_next;
    logic [OPW-1:0]      a_reg, a_next;
    logic [iask_pkg::DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [AW-1:0]       add_a, add_b;
    logic                add_cin;
    logic [AW:0]         add_sum;
    logic [AW-1:0]       shifted;

    assign shifted = {acc_reg[AW-2:0], bits_reg[BW-1]};
    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + (AW+1)'(add_cin);

    // One adder, operands chosen by operation and phase
    always_comb
    begin
        add_a   = acc_reg;
        add_b   = '0;
        add_cin = 1'b0;
        if (state_reg == U_FIN)
        begin
            // round half up: product bits 30 and above plus bit 29
            add_a = shifted;
            add_b = AW'(bits_reg[BW-2]);
        end
        else if (op_reg == iask_pkg::OP_DIV)
        begin
            add_a   = shifted;
            add_b   = ~AW'(den_reg);
            add_cin = 1'b1;
        end
        else if (bits_reg[0])
        begin
            add_b = AW'(a_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        bits_next  = bits_reg;
        a_next     = a_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            // a new command may follow straight out of the finishing cycle
            U_IDLE, U_FIN:
            begin
                state_next = U_IDLE;
                if (cmd.start)
                begin
                    op_next    = cmd.op;
                    a_next     = opa;
                    den_next   = den;
                    cnt_next   = '0;
                    state_next = U_RUN;
                    if (cmd.op == iask_pkg::OP_DIV)
                    begin
                        // quotient fits 31 bits, so start with dividend >> 31
                        acc_next  = AW'(opa[iask_pkg::COV_W-1:1]);
                        bits_next = {opa[0], {(BW-1){1'b0}}};
                    end
                    else
                    begin
                        acc_next  = '0;
                        bits_next = opb;
                    end
                end
            end
            U_RUN:
            begin
                if (op_reg == iask_pkg::OP_DIV)
                begin
                    acc_next  = add_sum[AW] ? add_sum[AW-1:0] : shifted;
                    bits_next = {bits_reg[BW-2:0], add_sum[AW]};
                end
                else
                begin
                    acc_next  = add_sum[AW:1];
                    bits_next = {add_sum[0], bits_reg[BW-1:1]};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    state_next = U_FIN;
                end
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            op_reg    <= iask_pkg::OP_MUL;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        bits_reg <= bits_next;
        a_reg    <= a_next;
        den_reg  <= den_next;
    end

    assign stat.busy = (state_reg != U_IDLE);
    assign stat.done = (state_reg == U_FIN);
    assign result    = (op_reg == iask_pkg::OP_DIV) ? OPW'(bits_reg) : add_sum[OPW-1:0];

endmodule
